### rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int INDEX_BITS  = 12;
   localparam int MAX_HANDLES = 1 << INDEX_BITS;
   localparam int COUNT_BITS  = INDEX_BITS + 1;
   localparam int GEN_BITS    = 16;
   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int CFG_BITS    = 13;

   typedef logic [INDEX_BITS-1:0]  index_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [GEN_BITS-1:0]    gen_type;
   typedef logic [MODE_BITS-1:0]   mode_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [CFG_BITS-1:0]    cfg_type;

   localparam mode_type MODE_CREATE  = 2'd0;
   localparam mode_type MODE_DESTROY = 2'd1;
   localparam mode_type MODE_CHECK   = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_STALE = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   localparam cfg_type MIN_FREE_RESET = cfg_type'(1024);

endpackage

### rtl/gha_if.sv
// ----------------------------------------------------------------------------
// gha channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gha_req_if;
   logic               valid;
   logic               ready;
   gha_pkg::mode_type  mode;
   gha_pkg::index_type handle_index;
   gha_pkg::gen_type   handle_generation;

   modport source (output valid, mode, handle_index, handle_generation, input ready);
   modport sink   (input valid, mode, handle_index, handle_generation, output ready);
endinterface

interface gha_rsp_if;
   logic                valid;
   logic                ready;
   gha_pkg::index_type  out_index;
   gha_pkg::gen_type    out_generation;
   gha_pkg::status_type status;

   modport source (output valid, out_index, out_generation, status, input ready);
   modport sink   (input valid, out_index, out_generation, status, output ready);
endinterface

interface gha_csr_if;
   logic             valid;
   logic             ready;
   gha_pkg::cfg_type min_free_before_reuse;

   modport source (output valid, min_free_before_reuse, input ready);
   modport sink   (input valid, min_free_before_reuse, output ready);
endinterface

### rtl/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Allocates, frees and checks handles made of an index and a generation.
// ----------------------------------------------------------------------------
//  channel   | dir | transaction
//  req_chan  | in  | mode, handle_index, handle_generation
//  rsp_chan  | out | out_index, out_generation, status
//  csr_chan  | in  | min_free_before_reuse (always ready)
//
//  destroy and check read the generation table, then respond; a fresh create
//  responds without a read; a create that reuses a freed index reads the free
//  stack, then the generation table. one request in flight; each memory has
//  one read and one write port. after reset a clearing pass zeroes the
//  generation table with req_chan.ready low.
//  a pending response holds the final step until rsp_chan drains it.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit (
   input logic         clock,
   input logic         reset,
   gha_req_if.sink     req_chan,
   gha_rsp_if.source   rsp_chan,
   gha_csr_if.sink     csr_chan
);
   import gha_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POP,
      ST_REUSE,
      ST_FRESH,
      ST_LOOKUP
   } state_type;

   gen_type   gen_mem [MAX_HANDLES];
   index_type stk_mem [MAX_HANDLES];

   logic      gen_we, gen_re, stk_we, stk_re;
   index_type gen_waddr, gen_raddr, stk_waddr, stk_raddr;
   gen_type   gen_wdata, gen_rdata_ff;
   index_type stk_wdata, stk_rdata_ff;

   state_type  state_ff, state_in;
   index_type  clr_ff, clr_in;
   count_type  free_count_ff, free_count_in;
   count_type  fresh_ff, fresh_in;
   cfg_type    min_free_ff, min_free_in;
   mode_type   mode_ff, mode_in;
   index_type  idx_ff, idx_in;
   gen_type    hgen_ff, hgen_in;
   logic       rsp_valid_ff, rsp_valid_in;
   index_type  rsp_index_ff, rsp_index_in;
   gen_type    rsp_gen_ff, rsp_gen_in;
   status_type rsp_status_ff, rsp_status_in;

   logic    out_free;
   logic    gen_match;
   gen_type gen_bumped;

   // generation table
   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_waddr] <= gen_wdata;
      end
      if (gen_re) begin
         gen_rdata_ff <= gen_mem[gen_raddr];
      end
   end

   // free stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stk_mem[stk_raddr];
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_index      = rsp_index_ff;
   assign rsp_chan.out_generation = rsp_gen_ff;
   assign rsp_chan.status         = rsp_status_ff;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign gen_match  = (gen_rdata_ff == hgen_ff);
   assign gen_bumped = gen_type'(gen_rdata_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      min_free_in   = min_free_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_status_in = rsp_status_ff;
      gen_we        = 1'b0;
      gen_waddr     = idx_ff;
      gen_wdata     = '0;
      gen_re        = 1'b0;
      gen_raddr     = req_chan.handle_index;
      stk_we        = 1'b0;
      stk_waddr     = free_count_ff[INDEX_BITS-1:0];
      stk_wdata     = idx_ff;
      stk_re        = 1'b0;
      stk_raddr     = index_type'(free_count_ff - 1'b1);

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_chan.valid) begin
         min_free_in = csr_chan.min_free_before_reuse;
      end

      case (state_ff)
         ST_CLEAR: begin
            gen_we    = 1'b1;
            gen_waddr = clr_ff;
            clr_in    = index_type'(clr_ff + 1'b1);
            if (clr_ff == index_type'(MAX_HANDLES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in = req_chan.mode;
               idx_in  = req_chan.handle_index;
               hgen_in = req_chan.handle_generation;
               if (req_chan.mode == MODE_CREATE) begin
                  if (free_count_ff > count_type'(min_free_ff)) begin
                     stk_re        = 1'b1;
                     free_count_in = count_type'(free_count_ff - 1'b1);
                     state_in      = ST_POP;
                  end else begin
                     state_in = ST_FRESH;
                  end
               end else begin
                  gen_re   = 1'b1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_POP: begin
            gen_re    = 1'b1;
            gen_raddr = stk_rdata_ff;
            state_in  = ST_REUSE;
         end
         ST_REUSE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = stk_rdata_ff;
               rsp_gen_in    = gen_rdata_ff;
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         ST_FRESH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_gen_in   = '0;
               if (fresh_ff == count_type'(MAX_HANDLES)) begin
                  rsp_index_in  = '0;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  gen_we        = 1'b1;
                  gen_waddr     = fresh_ff[INDEX_BITS-1:0];
                  fresh_in      = count_type'(fresh_ff + 1'b1);
                  rsp_index_in  = fresh_ff[INDEX_BITS-1:0];
                  rsp_status_in = STATUS_OK;
               end
            end
         end
         ST_LOOKUP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = idx_ff;
               rsp_gen_in    = gen_rdata_ff;
               rsp_status_in = gen_match ? STATUS_OK : STATUS_STALE;
               state_in      = ST_IDLE;
               if (mode_ff == MODE_DESTROY && gen_match) begin
                  gen_we     = 1'b1;
                  gen_wdata  = gen_bumped;
                  rsp_gen_in = gen_bumped;
                  // a full stack still bumps, but drops the push
                  if (free_count_ff != count_type'(MAX_HANDLES)) begin
                     stk_we        = 1'b1;
                     free_count_in = count_type'(free_count_ff + 1'b1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
         min_free_ff   <= MIN_FREE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         min_free_ff   <= min_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      hgen_ff       <= hgen_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

### rtl/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gha_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input gha_pkg::index_type  rsp_index,
   input gha_pkg::gen_type    rsp_generation,
   input gha_pkg::status_type rsp_status
);
   import gha_pkg::*;

   // reset starts the clearing pass with nothing pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("request or response open straight after reset");

   // one request in flight: the unit is busy the cycle after it takes one
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // a full response only ever reports index and generation zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_index == '0 && rsp_generation == '0)
      else $error("no-index response carries a handle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index)
         && $stable(rsp_generation) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_index      (rsp_chan.out_index),
   .rsp_generation (rsp_chan.out_generation),
   .rsp_status     (rsp_chan.status)
);

### tb/gha_handle_ledger_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_handle_ledger_pkg
// Shadow copy of the allocator's generation table, free stack and counters.
// It predicts the response for every accepted request and checks the
// responses against those predictions in order.
// ----------------------------------------------------------------------------
package gha_handle_ledger_pkg;

   import gha_pkg::*;

   // mode three decodes as a check
   localparam mode_type MODE_CHECK_ALT = 2'd3;

   typedef struct packed {
      index_type  out_index;
      gen_type    out_generation;
      status_type status;
   } handle_result_type;

   class handle_ledger;
      gen_type           gen_table[MAX_HANDLES];
      index_type         free_stack[MAX_HANDLES];
      int                free_count;
      int                next_fresh;
      cfg_type           min_free;
      handle_result_type awaited_handles[$];
      int                fails;

      function new();
         foreach (gen_table[i]) gen_table[i] = '0;
         free_count = 0;
         next_fresh = 0;
         min_free   = MIN_FREE_RESET;
         fails      = 0;
      endfunction

      function void set_threshold(cfg_type value);
         min_free = value;
      endfunction

      function void note_request(mode_type mode, index_type idx, gen_type gen);
         handle_result_type res;
         gen_type           stored;
         if (mode == MODE_CREATE) begin
            if (free_count > int'(min_free)) begin
               // lifo reuse of a freed index
               free_count--;
               res.out_index      = free_stack[free_count];
               res.out_generation = gen_table[res.out_index];
               res.status         = STATUS_OK;
            end else if (next_fresh >= MAX_HANDLES) begin
               res = '{out_index: '0, out_generation: '0, status: STATUS_FULL};
            end else begin
               res.out_index = index_type'(next_fresh);
               next_fresh++;
               gen_table[res.out_index] = '0;
               res.out_generation       = '0;
               res.status               = STATUS_OK;
            end
         end else begin
            stored        = gen_table[idx];
            res.out_index = idx;
            if (mode == MODE_DESTROY) begin
               if (stored != gen) begin
                  res.out_generation = stored;
                  res.status         = STATUS_STALE;
               end else begin
                  stored         = stored + 1'b1;
                  gen_table[idx] = stored;
                  // a full free stack still bumps the generation
                  if (free_count < MAX_HANDLES) begin
                     free_stack[free_count] = idx;
                     free_count++;
                  end
                  res.out_generation = stored;
                  res.status         = STATUS_OK;
               end
            end else begin
               res.out_generation = stored;
               res.status         = (stored == gen) ? STATUS_OK : STATUS_STALE;
            end
         end
         awaited_handles.push_back(res);
      endfunction

      function void check_response(index_type idx, gen_type gen, status_type status);
         handle_result_type exp;
         if (awaited_handles.size() == 0) begin
            $error("response transaction with nothing awaited: index %0d gen %0d status %0d",
                   idx, gen, status);
            fails++;
            return;
         end
         exp = awaited_handles.pop_front();
         if (idx !== exp.out_index) begin
            $error("out_index: expected %0d, got %0d", exp.out_index, idx);
            fails++;
         end
         if (gen !== exp.out_generation) begin
            $error("out_generation: expected %0d, got %0d", exp.out_generation, gen);
            fails++;
         end
         if (status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, status);
            fails++;
         end
      endfunction
   endclass

endpackage

### tb/generational_handle_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_tb
// Drives create, destroy and check requests through the allocator with bursty
// requests and a stalling response side, under several reuse thresholds.
// Covers lifo reuse, never-created indices, stale handles and the reuse
// threshold; every response is checked against a shadow ledger.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_tb;

   import gha_pkg::*;
   import gha_handle_ledger_pkg::*;

   logic clock;
   logic reset;

   gha_req_if req_chan ();
   gha_rsp_if rsp_chan ();
   gha_csr_if csr_chan ();

   generational_handle_allocator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   handle_ledger ledger = new();
   int           burst_left = 0;
   int           stall_left = 0;
   int           quiet_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("[generational_handle_allocator_unit] ERROR");
      $finish;
   end

   // response side: stalls now and then, with long quiet stretches
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (quiet_left > 0) begin
            rsp_chan.ready <= 1'b1;
            quiet_left--;
         end else begin
            case ($urandom_range(0, 15))
               0, 1, 2: begin
                  stall_left = $urandom_range(0, 4);
                  rsp_chan.ready <= 1'b0;
               end
               3: begin
                  quiet_left = $urandom_range(20, 200);
                  rsp_chan.ready <= 1'b1;
               end
               default: begin
                  rsp_chan.ready <= 1'b1;
               end
            endcase
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            ledger.check_response(rsp_chan.out_index, rsp_chan.out_generation,
                                  rsp_chan.status);
      end
   end

   task automatic send_request(mode_type mode, index_type idx, gen_type gen);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(50, 300);
         end else begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
         end
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid             <= 1'b1;
      req_chan.mode              <= mode;
      req_chan.handle_index      <= idx;
      req_chan.handle_generation <= gen;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ledger.note_request(mode, idx, gen);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (ledger.awaited_handles.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(cfg_type value);
      @(negedge clock);
      csr_chan.valid                 <= 1'b1;
      csr_chan.min_free_before_reuse <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      ledger.set_threshold(value);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // mostly indices already handed out, sometimes any index at all
   function automatic index_type pick_index();
      if (ledger.next_fresh > 0 && $urandom_range(0, 7) != 0)
         return index_type'($urandom_range(0, ledger.next_fresh - 1));
      return index_type'($urandom);
   endfunction

   task automatic send_random_request();
      mode_type  mode;
      index_type idx;
      gen_type   gen;
      int        pick;
      pick = $urandom_range(0, 99);
      idx  = pick_index();
      gen  = ledger.gen_table[idx];
      if (pick < 35) begin
         mode = MODE_CREATE;
         idx  = index_type'($urandom);
         gen  = gen_type'($urandom);
      end else if (pick < 65) begin
         mode = MODE_DESTROY;
      end else if (pick < 75) begin
         mode = MODE_DESTROY;
         gen  = gen + gen_type'($urandom_range(1, 65535));
      end else begin
         mode = (pick < 92) ? MODE_CHECK : MODE_CHECK_ALT;
         if ($urandom_range(0, 1) == 0) gen = gen_type'($urandom);
      end
      send_request(mode, idx, gen);
   endtask

   initial begin
      cfg_type thresholds[4];

      reset                      = 1'b1;
      req_chan.valid             = 1'b0;
      req_chan.mode              = MODE_CREATE;
      req_chan.handle_index      = '0;
      req_chan.handle_generation = '0;
      csr_chan.valid             = 1'b0;
      csr_chan.min_free_before_reuse = MIN_FREE_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // never-created indices read as generation 0
      send_request(MODE_CHECK, 12'd0, 16'd0);
      send_request(MODE_CHECK, 12'hFFF, 16'hFFFF);
      send_request(MODE_DESTROY, 12'd7, 16'd0);
      send_request(MODE_DESTROY, 12'd7, 16'd0);
      send_request(MODE_CHECK_ALT, 12'd7, 16'd1);
      send_request(MODE_CREATE, 12'hFFF, 16'hFFFF);
      send_request(MODE_CREATE, 12'd0, 16'd0);
      send_request(MODE_DESTROY, 12'd1, 16'd0);
      send_request(MODE_DESTROY, 12'hFFF, 16'd0);
      send_request(MODE_CHECK, 12'd1, 16'd1);
      send_request(MODE_CREATE, 12'd0, 16'd0);
      wait_idle();

      // reuse straight away: pops come back last in, first out
      write_threshold(cfg_type'(0));
      repeat (4) send_request(MODE_CREATE, 12'd0, 16'd0);
      send_request(MODE_DESTROY, 12'd7, 16'd1);
      send_request(MODE_CREATE, 12'd0, 16'd0);
      send_request(MODE_DESTROY, 12'hFFF, 16'hFFFF);
      wait_idle();

      write_threshold(cfg_type'(MAX_HANDLES));
      send_request(MODE_DESTROY, 12'd0, 16'd0);
      send_request(MODE_CREATE, 12'd0, 16'd0);
      wait_idle();

      thresholds = '{cfg_type'($urandom_range(0, 3)), cfg_type'($urandom_range(0, 15)),
                     cfg_type'(MAX_HANDLES - 1), cfg_type'($urandom_range(0, 8))};
      foreach (thresholds[t]) begin
         write_threshold(thresholds[t]);
         repeat (325) send_random_request();
         wait_idle();
      end

      write_threshold(cfg_type'(MAX_HANDLES - 1));
      send_request(MODE_CREATE, 12'd0, 16'd0);
      send_request(MODE_CREATE, 12'd0, 16'd0);
      wait_idle();

      write_threshold(MIN_FREE_RESET);
      repeat (40) send_random_request();

      wait_idle();
      repeat (8) @(posedge clock);
      if (ledger.fails == 0 && ledger.awaited_handles.size() == 0) begin
         $display("[generational_handle_allocator_unit] OK");
      end else begin
         if (ledger.awaited_handles.size() != 0)
            $error("%0d response transactions never arrived", ledger.awaited_handles.size());
         $display("[generational_handle_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
